@@ src/fscu_pkg.sv @@
// fscu_pkg: shared types and constants of the same-size fir convolution unit
// used by the interfaces, the sequencer, the tap cells and the output stage
package fscu_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int COEF_W         = 16;
	localparam int PROD_W         = SAMPLE_W + COEF_W;
	localparam int NUM_COEF       = 7;
	localparam int CFG_IDX_W      = 3;
	localparam int COEF_FRAC_BITS = 14;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	localparam sample_t SAMPLE_MAX = 16'sh7fff;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	// q1.14 defaults: 0.1, 0, -0.3, 0.2, 0.7, 0.6, 0.2
	localparam coef_t COEF_RESET [NUM_COEF] = '{
		16'sd1638, 16'sd0, -16'sd4915, 16'sd3277, 16'sd11469, 16'sd9830, 16'sd3277
	};

	// control that travels with one shift of the tap chain
	typedef struct packed {
		logic v;
		logic emit;
		logic last;
		logic clr;
	} ctl_t;

	typedef struct packed {
		ctl_t    ctl;
		sample_t x;
	} ev_t;

endpackage

@@ src/fscu_if.sv @@
// fscu_if: valid/ready channels for input samples and filtered results
// depends on fscu_pkg for the sample type
interface fscu_in_if import fscu_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;
	logic    row_end;

	modport source (output valid, output sample_in, output row_end, input ready);
	modport sink (input valid, input sample_in, input row_end, output ready);
endinterface

interface fscu_out_if import fscu_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    clipped;
	logic    row_last;

	modport source (output valid, output sample_out, output clipped, output row_last,
		input ready);
	modport sink (input valid, input sample_out, input clipped, input row_last,
		output ready);
endinterface

@@ src/fscu_seq.sv @@
// fscu_seq: turns accepted samples into shift events and adds the zero flush
// at the end of a row; depends on fscu_pkg and fscu_in_if
module fscu_seq import fscu_pkg::*; #(
	parameter int OFFSET = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	fscu_in_if.sink       samples,
	output ev_t           ev
);

	localparam int CNT_W = $clog2(OFFSET + 1);
	localparam logic [CNT_W-1:0] OFF_C = CNT_W'(OFFSET);

	logic             flush_q;
	logic             clr_q;
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] step_q;
	logic             take;
	logic [CNT_W:0]   reach;

	assign samples.ready = adv && !flush_q;
	assign take          = samples.valid && samples.ready;
	assign reach         = {1'b0, pos_q} + {1'b0, step_q};

	always_comb begin
		if (flush_q) begin
			ev.ctl.v    = adv;
			ev.ctl.emit = reach >= {1'b0, OFF_C};
			ev.ctl.last = step_q == OFF_C;
			ev.ctl.clr  = 1'b0;
			ev.x        = '0;
		end else begin
			ev.ctl.v    = take;
			ev.ctl.emit = seen_q == OFF_C;
			ev.ctl.last = 1'b0;
			ev.ctl.clr  = clr_q;
			ev.x        = samples.sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b0;
			clr_q   <= 1'b1;
			seen_q  <= '0;
			pos_q   <= '0;
			step_q  <= '0;
		end else if (flush_q) begin
			if (adv) begin
				if (step_q == OFF_C) begin
					flush_q <= 1'b0;
					clr_q   <= 1'b1;
				end else begin
					step_q <= step_q + CNT_W'(1);
				end
			end
		end else if (take) begin
			clr_q <= 1'b0;
			if (samples.row_end) begin
				flush_q <= 1'b1;
				step_q  <= CNT_W'(1);
				pos_q   <= seen_q;
				seen_q  <= '0;
			end else if (seen_q != OFF_C) begin
				seen_q <= seen_q + CNT_W'(1);
			end
		end
	end

endmodule

@@ src/fscu_cell.sv @@
// fscu_cell: one tap of the transposed fir chain, product then partial sum
// depends on fscu_pkg for sample, coefficient and control types
module fscu_cell import fscu_pkg::*; #(
	parameter int ACC_W = 35
) (
	input  logic                    clk,
	input  logic                    adv,
	input  sample_t                 x,
	input  coef_t                   coef,
	input  ctl_t                    ctl_s1,
	input  logic signed [ACC_W-1:0] sum_in,
	output logic signed [ACC_W-1:0] sum_s2
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  prod_ext;

	assign prod_ext = {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= x * coef;
		end
	end

	// first shift of a row drops the older partial sum
	always_ff @(posedge clk) begin
		if (adv && ctl_s1.v) begin
			sum_s2 <= ctl_s1.clr ? prod_ext : prod_ext + sum_in;
		end
	end

endmodule

@@ src/fscu_out.sv @@
// fscu_out: rounding, saturation and the output word register
// depends on fscu_pkg and fscu_out_if
module fscu_out import fscu_pkg::*; #(
	parameter int ACC_W = 35
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctl_t                    ctl_s2,
	input  logic signed [ACC_W-1:0] acc,
	fscu_out_if.source              results,
	output logic                    adv
);

	localparam int QW = ACC_W - COEF_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [ACC_W-1:0]    rnd;
	logic signed [QW-1:0]       quo;
	logic [QW-SAMPLE_W:0]       upper;
	logic                       ovf;
	sample_t                    sat;
	logic                       vld_q;
	sample_t                    data_q;
	logic                       clip_q;
	logic                       last_q;

	assign rnd   = acc + ROUND_C;
	assign quo   = rnd[ACC_W-1:COEF_FRAC_BITS];
	assign upper = quo[QW-1:SAMPLE_W-1];
	assign ovf   = !((&upper) || !(|upper));
	assign sat   = ovf ? (quo[QW-1] ? SAMPLE_MIN : SAMPLE_MAX) : quo[SAMPLE_W-1:0];

	assign adv = !vld_q || results.ready;

	assign results.valid      = vld_q;
	assign results.sample_out = data_q;
	assign results.clipped    = clip_q;
	assign results.row_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= ctl_s2.v && ctl_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= sat;
			clip_q <= ovf;
			last_q <= ctl_s2.last;
		end
	end

endmodule

@@ src/fir_same_convolution_unit.sv @@
// fir_same_convolution_unit: top level of the same-size zero-padded fir
// depends on fscu_pkg, fscu_if, fscu_seq, fscu_cell and fscu_out
//
// usage:
//   samples carries one word per sample of a row; row_end marks the last one.
//   results carries one word per output sample, row_last on the final one,
//   clipped when the rounded sum fell outside 16 bits.
//   taps are written through cfg_wr_en / cfg_index / cfg_data while idle;
//   an index past the last tap is dropped.
// throughput: one sample per cycle while results is not held off; after the word
//   with row_end, ready stays low while zeros are shifted through the chain.
// path: the word that completes a result passes the product register, the partial
//   sum register and the output register before the result is valid.
// structure: a chain of TAPS cells in transposed form, each with one
//   multiplier and one adder, passing its partial sum to its neighbor.
// reset: taps return to their defaults, the chain control and row counters clear;
//   the product and partial sum registers are not reset. stall: while results is
//   held off the whole chain freezes and ready drops; the output register holds its word until taken.
module fir_same_convolution_unit import fscu_pkg::*; #(
	parameter int TAPS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fscu_in_if.sink              samples,
	fscu_out_if.source           results,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	localparam int OFFSET = TAPS / 2;
	localparam int ACC_W  = PROD_W + $clog2(TAPS);

	coef_t                   coef_q [NUM_COEF];
	ev_t                     ev;
	ctl_t                    ctl_s1;
	ctl_t                    ctl_s2;
	logic                    adv;
	logic signed [ACC_W-1:0] sum_s2 [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= COEF_RESET[i];
			end
		end else if (cfg_wr_en) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					coef_q[i] <= cfg_data;
				end
			end
		end
	end

	fscu_seq #(
		.OFFSET (OFFSET)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.samples (samples),
		.ev      (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ev.ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	for (genvar j = 0; j < TAPS; j++) begin : g_cell
		coef_t                   tap_coef;
		logic signed [ACC_W-1:0] tap_in;

		if (j < NUM_COEF) begin : g_coef
			assign tap_coef = coef_q[j];
		end else begin : g_zero
			assign tap_coef = '0;
		end

		if (j == TAPS - 1) begin : g_end
			assign tap_in = '0;
		end else begin : g_link
			assign tap_in = sum_s2[j+1];
		end

		fscu_cell #(
			.ACC_W (ACC_W)
		) u_cell (
			.clk    (clk),
			.adv    (adv),
			.x      (ev.x),
			.coef   (tap_coef),
			.ctl_s1 (ctl_s1),
			.sum_in (tap_in),
			.sum_s2 (sum_s2[j])
		);
	end

	fscu_out #(
		.ACC_W (ACC_W)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s2  (ctl_s2),
		.acc     (sum_s2[0]),
		.results (results),
		.adv     (adv)
	);

`ifndef SYNTHESIS
	// a row end always starts a flush, so the next cycle takes no sample
	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready && samples.row_end |=> !samples.ready)
		else $error("sample taken right after row end");

	// a held result freezes the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |-> !samples.ready)
		else $error("sample taken while output stalled");

	// the final flush shift of a row always produces a word
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.v && ctl_s2.last |-> ctl_s2.emit)
		else $error("row last without output");

	// the first sample of a row never completes an output
	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.v && ctl_s1.clr |-> !ctl_s1.emit)
		else $error("output on first sample of row");

	// a frozen pipeline keeps its control
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_s2))
		else $error("pipeline moved while stalled");
`endif

endmodule

@@ bench/fir_same_convolution_unit_tb.sv @@
`timescale 1ns / 100ps
// fir_same_convolution_unit_tb: self-checking bench for the same-size 7-tap fir, directed
// table then random rows, with a predictor kept in step; depends on fscu_pkg, fscu_if
// and fir_same_convolution_unit
module fir_same_convolution_unit_tb;
	import fscu_pkg::*;

	localparam int TAPS           = 7;
	localparam int HALF           = TAPS / 2;
	localparam int MAX_PER_WORD   = HALF + 1;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_WORDS    = 34;
	localparam logic [CFG_IDX_W-1:0] TAP_IDX_NONE = CFG_IDX_W'(NUM_COEF);

	typedef struct {
		sample_t sample_out;
		logic    clipped;
		logic    row_last;
	} fir_out_t;

	typedef enum logic {STEP_WORD, STEP_TAPS} plan_op_e;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	// op, sample (or value for every tap), row_end, typed, result count, result, clipped
	typedef struct packed {
		plan_op_e   op;
		sample_t    x;
		logic       row_end;
		logic       typed;
		logic [2:0] n_out;
		sample_t    y;
		logic       clip;
	} plan_row_t;

	localparam int PLAN_LEN = 25;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{STEP_WORD, 16'sd0,      1'b1, 1'b1, 3'd1, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MAX,  1'b1, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MIN,  1'b1, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'sh5555,   1'b0, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'shaaaa,   1'b1, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'sd1,      1'b0, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, -16'sd1,     1'b0, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'sd12345,  1'b1, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'sd0,      1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'sd0,      1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'sd0,      1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, 16'sd0,      1'b1, 1'b1, 3'd4, 16'sd0,     1'b0},
		'{STEP_TAPS, SAMPLE_MAX,  1'b0, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MAX,  1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MAX,  1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MAX,  1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MAX,  1'b0, 1'b1, 3'd1, SAMPLE_MAX, 1'b1},
		'{STEP_WORD, SAMPLE_MAX,  1'b0, 1'b1, 3'd1, SAMPLE_MAX, 1'b1},
		'{STEP_WORD, SAMPLE_MAX,  1'b0, 1'b1, 3'd1, SAMPLE_MAX, 1'b1},
		'{STEP_WORD, SAMPLE_MAX,  1'b1, 1'b1, 3'd4, SAMPLE_MAX, 1'b1},
		'{STEP_TAPS, SAMPLE_MIN,  1'b0, 1'b0, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MIN,  1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MIN,  1'b0, 1'b1, 3'd0, 16'sd0,     1'b0},
		'{STEP_WORD, SAMPLE_MIN,  1'b1, 1'b1, 3'd3, SAMPLE_MAX, 1'b1},
		'{STEP_WORD, SAMPLE_MAX,  1'b1, 1'b1, 3'd1, SAMPLE_MIN, 1'b1}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	fscu_in_if  samples_ch ();
	fscu_out_if results_ch ();

	fir_same_convolution_unit #(.TAPS(TAPS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_ch),
		.results   (results_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	sample_t  hist [TAPS];
	int       row_seen;
	coef_t    tap_w [NUM_COEF];
	fir_out_t due_words [$];

	int       errors = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	rx_mode_e rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void shift_hist(sample_t x);
		int i;
		for (i = TAPS - 1; i > 0; i--)
			hist[i] = hist[i - 1];
		hist[0] = x;
	endfunction

	// one centred output from the current window: round half up, floor shift, saturate
	function automatic fir_out_t fir_point(logic last);
		longint   acc;
		longint   q;
		fir_out_t r;
		int       j;
		acc = 0;
		for (j = 0; j < TAPS; j++)
			if (j < NUM_COEF)
				acc += longint'(tap_w[j]) * longint'(hist[j]);
		acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
		q = acc >>> COEF_FRAC_BITS;
		r.clipped = 1'b0;
		if (q > longint'(SAMPLE_MAX)) begin
			q = SAMPLE_MAX;
			r.clipped = 1'b1;
		end else if (q < longint'(SAMPLE_MIN)) begin
			q = SAMPLE_MIN;
			r.clipped = 1'b1;
		end
		r.sample_out = sample_t'(q);
		r.row_last = last;
		return r;
	endfunction

	// advance the row by one word; the word with row_end also flushes with zeros
	function automatic int fir_advance(sample_t x, logic e, output fir_out_t res [MAX_PER_WORD]);
		int pos;
		int n;
		int t;
		pos = row_seen;
		n = 0;
		shift_hist(x);
		if (pos >= HALF) begin
			res[n] = fir_point(1'b0);
			n++;
		end
		if (row_seen < HALF)
			row_seen++;
		if (e) begin
			for (t = 1; t <= HALF; t++) begin
				shift_hist('0);
				if (pos + t >= HALF) begin
					res[n] = fir_point(t == HALF);
					n++;
				end
			end
			for (t = 0; t < TAPS; t++)
				hist[t] = '0;
			row_seen = 0;
		end
		return n;
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic put_word(sample_t x, logic e, logic typed, int n, sample_t y, logic clip);
		fir_out_t res [MAX_PER_WORD];
		fir_out_t w;
		int       cnt;
		int       gap;
		int       j;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				samples_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		samples_ch.valid     <= 1'b1;
		samples_ch.sample_in <= x;
		samples_ch.row_end   <= e;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		cnt = fir_advance(x, e, res);
		if (typed) begin
			for (j = 0; j < n; j++) begin
				w.sample_out = y;
				w.clipped = clip;
				w.row_last = e && (j == n - 1);
				due_words.push_back(w);
			end
		end else begin
			for (j = 0; j < cnt; j++)
				due_words.push_back(res[j]);
		end
		burst_left--;
		@(negedge clk);
	endtask

	// taps change only with the chain empty: every phase ends on a row_end
	task automatic load_taps(coef_t w [NUM_COEF]);
		int i;
		samples_ch.valid <= 1'b0;
		wait (due_words.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		for (i = 0; i < NUM_COEF; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= w[i];
			@(negedge clk);
			tap_w[i] = w[i];
		end
		// index past the last tap must be dropped
		cfg_index <= TAP_IDX_NONE;
		cfg_data  <= COEF_W'($urandom);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 120);
		end else begin
			rx_left--;
		end
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   results_ch.ready <= 1'b1;
			RX_COIN:   results_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: results_ch.ready <= ($urandom_range(0, 3) == 0);
			default:   results_ch.ready <= (rx_tick % 5) < 2;
		endcase
	end

	always @(posedge clk) begin
		fir_out_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (due_words.size() == 0) begin
				$error("unexpected word: sample_out %0d clipped %0b row_last %0b",
					results_ch.sample_out, results_ch.clipped, results_ch.row_last);
				errors++;
			end else begin
				want = due_words.pop_front();
				if (results_ch.sample_out !== want.sample_out) begin
					$error("sample_out: expected %0d, got %0d", want.sample_out,
						results_ch.sample_out);
					errors++;
				end
				if (results_ch.clipped !== want.clipped) begin
					$error("clipped: expected %0b, got %0b", want.clipped, results_ch.clipped);
					errors++;
				end
				if (results_ch.row_last !== want.row_last) begin
					$error("row_last: expected %0b, got %0b", want.row_last,
						results_ch.row_last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fir_same_convolution_unit_tb: errors");
			$finish;
		end
	end

	initial begin
		coef_t   w [NUM_COEF];
		sample_t x;
		int      i;
		int      phase;
		int      sent;
		int      len;
		int      k;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.sample_in = '0;
		samples_ch.row_end = 1'b0;
		results_ch.ready = 1'b0;
		for (i = 0; i < TAPS; i++)
			hist[i] = '0;
		for (i = 0; i < NUM_COEF; i++)
			tap_w[i] = COEF_RESET[i];
		row_seen = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (PLAN[r]) begin
			if (PLAN[r].op == STEP_TAPS) begin
				for (i = 0; i < NUM_COEF; i++)
					w[i] = PLAN[r].x;
				load_taps(w);
			end else begin
				put_word(PLAN[r].x, PLAN[r].row_end, PLAN[r].typed, PLAN[r].n_out, PLAN[r].y,
					PLAN[r].clip);
			end
		end

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			// full range, small, defaults again, near identity
			for (i = 0; i < NUM_COEF; i++)
				case (phase % 4)
					0:       w[i] = coef_t'($urandom);
					1:       w[i] = coef_t'(int'($urandom_range(0, 12000)) - 6000);
					2:       w[i] = COEF_RESET[i];
					default: w[i] = (i == HALF) ? 16'sd16384 :
						coef_t'(int'($urandom_range(0, 2000)) - 1000);
				endcase
			load_taps(w);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, HALF) :
					$urandom_range(HALF + 1, 24);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 9))
						0:       x = SAMPLE_MAX;
						1:       x = SAMPLE_MIN;
						2, 3, 4: x = sample_t'(int'($urandom_range(0, 4000)) - 2000);
						default: x = sample_t'($urandom);
					endcase
					put_word(x, k == len - 1, 1'b0, 0, '0, 1'b0);
				end
				sent += len;
			end
		end

		samples_ch.valid <= 1'b0;
		wait (due_words.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("fir_same_convolution_unit_tb: clean");
		else
			$display("fir_same_convolution_unit_tb: errors");
		$finish;
	end

endmodule
